// ===== hdl/irtd_pkg.sv =====
// ---------------------------------------------------------------------------
// irtd_pkg: shared types and codes of the report timestamp decoder
// Beat layouts, configuration register indexes, outcome codes and the
// per-item record passed from the time front end to the tracker.
// ---------------------------------------------------------------------------
package irtd_pkg;

	// configuration register indexes
	localparam logic [7:0] REG_TIMEBASE_CODE = 8'd0;
	localparam logic [7:0] REG_ACCEL_CODE    = 8'd1;
	localparam logic [7:0] REG_GYRO_CODE     = 8'd2;
	localparam logic [7:0] REG_MAG_CODE      = 8'd3;
	localparam logic [7:0] REG_FAILURE_LIMIT = 8'd4;

	// reset values of the configuration registers
	localparam logic [7:0] RST_TIMEBASE_CODE = 8'd251;
	localparam logic [7:0] RST_ACCEL_CODE    = 8'd1;
	localparam logic [7:0] RST_GYRO_CODE     = 8'd2;
	localparam logic [7:0] RST_MAG_CODE      = 8'd3;
	localparam logic [3:0] RST_FAILURE_LIMIT = 4'd10;

	// outcome codes
	localparam logic [2:0] OUT_ACCEL     = 3'd0;
	localparam logic [2:0] OUT_GYRO      = 3'd1;
	localparam logic [2:0] OUT_MAG       = 3'd2;
	localparam logic [2:0] OUT_STALE     = 3'd3;
	localparam logic [2:0] OUT_UNKNOWN   = 3'd4;
	localparam logic [2:0] OUT_NOT_TB    = 3'd5;
	localparam logic [2:0] OUT_NEG_DELTA = 3'd6;

	// header check result
	localparam logic [1:0] CHK_OK      = 2'd0;
	localparam logic [1:0] CHK_NOT_TB  = 2'd1;
	localparam logic [1:0] CHK_NEG     = 2'd2;

	// sensor selected by the sample report id
	localparam logic [1:0] SEL_ACCEL = 2'd0;
	localparam logic [1:0] SEL_GYRO  = 2'd1;
	localparam logic [1:0] SEL_MAG   = 2'd2;
	localparam logic [1:0] SEL_NONE  = 2'd3;

	localparam int IN_DATA_W  = 168;
	localparam int IN_USER_W  = 8;
	localparam int OUT_DATA_W = 128;
	localparam int OUT_USER_W = 8;

	// input tdata, last member in the lowest bits
	typedef struct packed {
		logic        pad;
		logic [15:0] axis_z;
		logic [15:0] axis_y;
		logic [15:0] axis_x;
		logic [7:0]  delay_low_byte;
		logic [7:0]  status_byte;
		logic [31:0] delta_ticks;
		logic [7:0]  lead_report_code;
		logic [62:0] host_time_us;
	} in_beat_t;

	// output tdata, last member in the lowest bits
	typedef struct packed {
		logic [6:0]  pad;
		logic        reset_request;
		logic [7:0]  tx_sequence;
		logic [15:0] out_z;
		logic [15:0] out_y;
		logic [15:0] out_x;
		logic [63:0] sample_time_us;
	} out_beat_t;

	typedef struct packed {
		logic [7:0] timebase_report_code;
		logic [7:0] accel_report_code;
		logic [7:0] gyro_report_code;
		logic [7:0] mag_report_code;
		logic [3:0] failure_limit;
	} cfg_t;

	// one decoded report on its way to the tracker
	typedef struct packed {
		logic [1:0]  chk;
		logic [1:0]  sel;
		logic [63:0] sample_time;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
	} item_t;

endpackage

// ===== hdl/imu_report_timestamp_decoder_top.sv =====
// ---------------------------------------------------------------------------
// imu_report_timestamp_decoder_top: sensor-hub report timestamp decoder
// Path: input register, time register, result register, from an input beat
// to its result beat; throughput one report per cycle when m_tready is not
// held low, set by the freshness compare and counter update in the tracker.
// Reset: arst_n clears all valid flags, per-sensor times, the failure and
// sequence counters, and loads the default report codes and limit.
// ---------------------------------------------------------------------------
module imu_report_timestamp_decoder_top import irtd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// host_time_us, lead_report_code, delta_ticks, status_byte,
	// delay_low_byte, axis_x, axis_y, axis_z
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// sample_report_code
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// sample_time_us, out_x, out_y, out_z, tx_sequence, reset_request
	output logic [OUT_DATA_W-1:0] m_tdata,
	// outcome
	output logic [OUT_USER_W-1:0] m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_index,
	input  logic [7:0]            cfg_data
);

	cfg_t  cfg;
	logic  item_valid;
	logic  item_ready;
	item_t item;

	// configuration writes always taken
	assign cfg_ready = 1'b1;

	irtd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	irtd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.cfg        (cfg),
		.nxt_ready  (item_ready),
		.item_valid (item_valid),
		.item       (item)
	);

	irtd_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// ===== hdl/irtd_cfg.sv =====
// ---------------------------------------------------------------------------
// irtd_cfg: configuration registers
// Holds the report id codes and the failure limit, written by index.
// ---------------------------------------------------------------------------
module irtd_cfg import irtd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	// indexed register write, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timebase_report_code <= RST_TIMEBASE_CODE;
			cfg_q.accel_report_code    <= RST_ACCEL_CODE;
			cfg_q.gyro_report_code     <= RST_GYRO_CODE;
			cfg_q.mag_report_code      <= RST_MAG_CODE;
			cfg_q.failure_limit        <= RST_FAILURE_LIMIT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TIMEBASE_CODE: cfg_q.timebase_report_code <= cfg_data;
				REG_ACCEL_CODE:    cfg_q.accel_report_code    <= cfg_data;
				REG_GYRO_CODE:     cfg_q.gyro_report_code     <= cfg_data;
				REG_MAG_CODE:      cfg_q.mag_report_code      <= cfg_data;
				REG_FAILURE_LIMIT: cfg_q.failure_limit        <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/irtd_front.sv =====
// ---------------------------------------------------------------------------
// irtd_front: input register and sample time calculation
// Registers the report beat, checks the timebase header, computes the
// wrapping sample time and sorts the sensor by report id.
// ---------------------------------------------------------------------------
module irtd_front import irtd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic [IN_USER_W-1:0] s_tuser,
	input  cfg_t                 cfg,
	input  logic                 nxt_ready,
	output logic                 item_valid,
	output item_t                item
);

	logic                 valid_s1;
	in_beat_t             beat_s1;
	logic [7:0]           code_s1;
	logic                 valid_s2;
	item_t                item_s2;
	logic                 ready_s1;
	logic                 ready_s2;
	item_t                item_c;
	logic [13:0]          dticks;
	logic [39:0]          diff;
	logic [39:0]          diff_us;
	logic [63:0]          t_sum;

	// stage ready chain
	assign ready_s2 = !valid_s2 || nxt_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= s_tvalid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	// input beat register
	always_ff @(posedge clk) begin
		if (s_tvalid && ready_s1) begin
			beat_s1 <= in_beat_t'(s_tdata);
			code_s1 <= s_tuser;
		end
	end

	// time = host + (delay - base delta) * 100, wrapping at 64 bits
	always_comb begin
		dticks  = {beat_s1.status_byte[7:2], beat_s1.delay_low_byte};
		diff    = {26'd0, dticks} - {{8{beat_s1.delta_ticks[31]}},
			beat_s1.delta_ticks};
		diff_us = (diff << 6) + (diff << 5) + (diff << 2);
		t_sum   = {1'b0, beat_s1.host_time_us} + {{24{diff_us[39]}}, diff_us};
	end

	// header check, sensor sort, zeroed payload on rejection
	always_comb begin
		item_c.sample_time = t_sum;
		item_c.x           = beat_s1.axis_x;
		item_c.y           = beat_s1.axis_y;
		item_c.z           = beat_s1.axis_z;
		priority if (beat_s1.lead_report_code != cfg.timebase_report_code)
			item_c.chk = CHK_NOT_TB;
		else if (beat_s1.delta_ticks[31])
			item_c.chk = CHK_NEG;
		else
			item_c.chk = CHK_OK;
		if (item_c.chk != CHK_OK) begin
			item_c.sample_time = '0;
			item_c.x           = '0;
			item_c.y           = '0;
			item_c.z           = '0;
		end
		priority if (code_s1 == cfg.accel_report_code) item_c.sel = SEL_ACCEL;
		else if (code_s1 == cfg.gyro_report_code)      item_c.sel = SEL_GYRO;
		else if (code_s1 == cfg.mag_report_code)       item_c.sel = SEL_MAG;
		else                                           item_c.sel = SEL_NONE;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) item_s2 <= item_c;
	end

	assign item_valid = valid_s2;
	assign item       = item_s2;

endmodule

// ===== hdl/irtd_track.sv =====
// ---------------------------------------------------------------------------
// irtd_track: per-sensor freshness, failure counting and result register
// Compares each sample time with the last accepted time of its sensor,
// keeps the failure counter and sequence number, and holds the result beat.
// ---------------------------------------------------------------------------
module irtd_track import irtd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  item_valid,
	input  item_t                 item,
	output logic                  item_ready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser
);

	logic [63:0] last_accel_q;
	logic [63:0] last_gyro_q;
	logic [63:0] last_mag_q;
	logic [4:0]  fail_q;
	logic [7:0]  seq_q;
	logic        valid_s3;
	out_beat_t   beat_s3;
	logic [2:0]  outcome_s3;
	logic        take;
	logic [63:0] last_sel;
	logic        fresh;
	logic [2:0]  outcome_c;
	logic [4:0]  fail_inc;
	logic [4:0]  fail_nxt;
	logic        rst_c;

	assign item_ready = !valid_s3 || m_tready;
	assign take       = item_valid && item_ready;

	// last time of the selected sensor and the freshness compare
	always_comb begin
		unique case (item.sel)
			SEL_ACCEL: last_sel = last_accel_q;
			SEL_GYRO:  last_sel = last_gyro_q;
			SEL_MAG:   last_sel = last_mag_q;
			default:   last_sel = '1;
		endcase
		fresh = item.sample_time > last_sel;
	end

	// outcome code
	always_comb begin
		unique case (item.chk)
			CHK_NOT_TB: outcome_c = OUT_NOT_TB;
			CHK_NEG:    outcome_c = OUT_NEG_DELTA;
			default: begin
				unique case (item.sel)
					SEL_ACCEL: outcome_c = fresh ? OUT_ACCEL : OUT_STALE;
					SEL_GYRO:  outcome_c = fresh ? OUT_GYRO : OUT_STALE;
					SEL_MAG:   outcome_c = fresh ? OUT_MAG : OUT_STALE;
					default:   outcome_c = OUT_UNKNOWN;
				endcase
			end
		endcase
	end

	// failure counter step and reset request
	always_comb begin
		fail_inc = fail_q + 5'd1;
		rst_c    = 1'b0;
		if (item.chk == CHK_OK) begin
			fail_nxt = (fail_q != 5'd0) ? fail_q - 5'd1 : fail_q;
		end else if (fail_inc > {1'b0, cfg.failure_limit}) begin
			fail_nxt = 5'd0;
			rst_c    = 1'b1;
		end else begin
			fail_nxt = fail_inc;
		end
	end

	// tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_accel_q <= '0;
			last_gyro_q  <= '0;
			last_mag_q   <= '0;
			fail_q       <= '0;
			seq_q        <= '0;
			valid_s3     <= 1'b0;
		end else begin
			if (item_ready) valid_s3 <= item_valid;
			if (take) begin
				fail_q <= fail_nxt;
				seq_q  <= seq_q + 8'd1;
				if (outcome_c == OUT_ACCEL) last_accel_q <= item.sample_time;
				if (outcome_c == OUT_GYRO)  last_gyro_q  <= item.sample_time;
				if (outcome_c == OUT_MAG)   last_mag_q   <= item.sample_time;
			end
		end
	end

	// result beat register
	always_ff @(posedge clk) begin
		if (take) begin
			beat_s3.pad            <= '0;
			beat_s3.reset_request  <= rst_c;
			beat_s3.tx_sequence    <= seq_q;
			beat_s3.out_z          <= item.z;
			beat_s3.out_y          <= item.y;
			beat_s3.out_x          <= item.x;
			beat_s3.sample_time_us <= item.sample_time;
			outcome_s3             <= outcome_c;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = beat_s3;
	assign m_tuser  = {5'd0, outcome_s3};

endmodule

// ===== hdl/irtd_checker.sv =====
// ---------------------------------------------------------------------------
// irtd_checker: port-level checks of the decoder
// Watches the result stream for held stalls, sequence order and the
// contents of rejected reports.
// ---------------------------------------------------------------------------
module irtd_checker import irtd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed under stall");

	// back-to-back beats carry consecutive sequence numbers
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) ##1 (m_tvalid && m_tready) |->
		m_tdata[119:112] == 8'($past(m_tdata[119:112]) + 8'd1))
		else $error("sequence number skipped");

	// rejected reports carry no time or samples
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] == OUT_NOT_TB || m_tuser[2:0] == OUT_NEG_DELTA) |->
		m_tdata[111:0] == '0)
		else $error("rejected report carries payload");

	// reset request only on a failed report
	a_reset_req: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[120] |->
		(m_tuser[2:0] == OUT_NOT_TB || m_tuser[2:0] == OUT_NEG_DELTA))
		else $error("reset request on a good report");

endmodule

bind imu_report_timestamp_decoder_top irtd_checker u_irtd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
